// File: sv/hem_pkg.sv
// Shared constants, types and helper function of the HDR exposure merge pipeline.
package hem_pkg;

  // Number of exposures merged per pixel, darkest first (2 to 6).
  localparam int NUM_EXPOSURES = 4;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 20;
  localparam int RAD_W    = 20;
  localparam int CFG_W    = 20;

  // Configuration register indexes; gain k (k >= 1) sits at REG_GAIN_FIRST + k - 1.
  localparam int REG_LOW_THRESHOLD  = 0;
  localparam int REG_HIGH_THRESHOLD = 1;
  localparam int REG_GAIN_FIRST     = 2;
  localparam int NUM_REGS           = NUM_EXPOSURES + 1;
  localparam int CFG_IDX_W          = $clog2(NUM_REGS);

  // Reset values.
  localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 16'd655;
  localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 16'd64880;
  localparam logic [GAIN_W-1:0]   UNITY_GAIN         = 20'd65536;
  localparam logic [RAD_W-1:0]    RAD_MAX            = '1;

  // Arithmetic widths.
  localparam int FRAC_W       = 16;
  localparam int HALF_SHIFT   = FRAC_W - 1;
  localparam int PROD_W       = SAMPLE_W + GAIN_W;
  localparam int CNT_W        = $clog2(NUM_EXPOSURES + 1);
  localparam int SUM_W        = PROD_W + CNT_W;
  localparam int Q_W          = SUM_W - FRAC_W;
  localparam int RECIP_SHIFT  = Q_W;
  localparam int RECIP_W      = RECIP_SHIFT + 1;
  localparam int MUL_W        = Q_W + RECIP_W;
  localparam int BACK_W       = Q_W + CNT_W;

  // Stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = ((NUM_EXPOSURES * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RAD_W + 7) / 8) * 8;

  localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(1) << RECIP_SHIFT;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [SAMPLE_W-1:0]                        low_threshold;
    logic [SAMPLE_W-1:0]                        high_threshold;
    logic [NUM_EXPOSURES-2:0][GAIN_W-1:0]       inverse_gain;
  } cfg_t;

  // After the weight and multiply stage.
  typedef struct packed {
    logic [NUM_EXPOSURES-1:0][PROD_W-1:0] prod;
    logic [CNT_W-1:0]                     count;
    logic [SAMPLE_W-1:0]                  darkest;
  } prod_t;

  // After the sum stage: rounded sum in Q4.16 units, before division by the count.
  typedef struct packed {
    logic [Q_W-1:0]      scaled;
    logic [CNT_W-1:0]    count;
    logic [SAMPLE_W-1:0] darkest;
  } sum_t;

  // After the reciprocal multiply: quotient estimate, low by at most one.
  typedef struct packed {
    logic [Q_W-1:0]      quot_est;
    logic [Q_W-1:0]      scaled;
    logic [CNT_W-1:0]    count;
    logic [SAMPLE_W-1:0] darkest;
  } quot_t;

  // Floor of 2^RECIP_SHIFT over the weight count; zero count gives zero.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (int'(cnt))
      1:       r = RECIP_ONE;
      2:       r = RECIP_ONE / 2;
      3:       r = RECIP_ONE / 3;
      4:       r = RECIP_ONE / 4;
      5:       r = RECIP_ONE / 5;
      6:       r = RECIP_ONE / 6;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/hem_cfg_regs.sv
// Configuration register file: thresholds and per-exposure inverse gains.
module hem_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hem_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hem_pkg::CFG_W-1:0]     cfg_data_i,
  output hem_pkg::cfg_t                 cfg_o
);
  import hem_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      if (cfg_index_i == CFG_IDX_W'(REG_LOW_THRESHOLD)) begin
        cfg_d.low_threshold = cfg_data_i[SAMPLE_W-1:0];
      end
      if (cfg_index_i == CFG_IDX_W'(REG_HIGH_THRESHOLD)) begin
        cfg_d.high_threshold = cfg_data_i[SAMPLE_W-1:0];
      end
      for (int k = 0; k < NUM_EXPOSURES - 1; k++) begin
        if (cfg_index_i == CFG_IDX_W'(REG_GAIN_FIRST + k)) begin
          cfg_d.inverse_gain[k] = cfg_data_i[GAIN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold  <= LOW_THRESHOLD_RST;
      cfg_q.high_threshold <= HIGH_THRESHOLD_RST;
      for (int k = 0; k < NUM_EXPOSURES - 1; k++) begin
        cfg_q.inverse_gain[k] <= UNITY_GAIN;
      end
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/hem_weight_mul.sv
// First stage: per-exposure weight decision and gain multiply, one lane per exposure.
module hem_weight_mul (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             en_i,
  input  logic                                             valid_i,
  input  logic [hem_pkg::NUM_EXPOSURES*hem_pkg::SAMPLE_W-1:0] samples_i,
  input  hem_pkg::cfg_t                                    cfg_i,
  output logic                                             valid_o,
  output hem_pkg::prod_t                                   data_o
);
  import hem_pkg::*;

  logic [NUM_EXPOSURES-1:0] use_w;
  prod_t                    data_d, data_q;
  logic                     valid_q;

  // Weight rules: in range counts; the darkest also counts when saturated,
  // the brightest also counts when too dark.
  always_comb begin
    logic [SAMPLE_W-1:0] s;
    logic [GAIN_W-1:0]   g;
    for (int k = 0; k < NUM_EXPOSURES; k++) begin
      s = samples_i[k*SAMPLE_W +: SAMPLE_W];
      use_w[k] = (s >= cfg_i.low_threshold) && (s <= cfg_i.high_threshold);
      if (k == 0 && s >= cfg_i.high_threshold) begin
        use_w[k] = 1'b1;
      end
      if (k == NUM_EXPOSURES - 1 && s <= cfg_i.low_threshold) begin
        use_w[k] = 1'b1;
      end
      g = (k == 0) ? UNITY_GAIN : cfg_i.inverse_gain[(k == 0) ? 0 : k - 1];
      data_d.prod[k] = use_w[k] ? (PROD_W'(s) * PROD_W'(g)) : '0;
    end
    data_d.count   = CNT_W'($countones(use_w));
    data_d.darkest = samples_i[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: sv/hem_accum.sv
// Second stage: sum of weighted products plus half an output step per weight.
module hem_accum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  hem_pkg::prod_t  data_i,
  output logic            valid_o,
  output hem_pkg::sum_t   data_o
);
  import hem_pkg::*;

  logic [SUM_W-1:0] acc;
  sum_t             data_d, data_q;
  logic             valid_q;

  // Rounding offset count * 2^15 folded into the sum, then drop 16 fraction bits.
  always_comb begin
    acc = SUM_W'({data_i.count, HALF_SHIFT'(0)});
    for (int k = 0; k < NUM_EXPOSURES; k++) begin
      acc = acc + SUM_W'(data_i.prod[k]);
    end
    data_d.scaled  = acc[SUM_W-1:FRAC_W];
    data_d.count   = data_i.count;
    data_d.darkest = data_i.darkest;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: sv/hem_divide.sv
// Third and fourth stages: divide by the weight count through a reciprocal,
// correct the estimate, saturate and select the fallback.
module hem_divide (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  hem_pkg::sum_t             data_i,
  output logic                      valid_o,
  output logic [hem_pkg::RAD_W-1:0] radiance_o,
  output logic                      fallback_o,
  output hem_pkg::quot_t            quot_o
);
  import hem_pkg::*;

  logic [MUL_W-1:0]  mul;
  quot_t             quot_d, quot_q;
  logic              quot_valid_q;
  logic [BACK_W-1:0] back;
  logic [Q_W-1:0]    rem;
  logic [Q_W-1:0]    quot;
  logic [RAD_W-1:0]  radiance_d, radiance_q;
  logic              fallback_d, fallback_q;
  logic              out_valid_q;

  // Quotient estimate from the truncated reciprocal; it is exact or one low.
  always_comb begin
    mul = MUL_W'(data_i.scaled) * MUL_W'(recip(data_i.count));
    quot_d.quot_est = mul[RECIP_SHIFT +: Q_W];
    quot_d.scaled   = data_i.scaled;
    quot_d.count    = data_i.count;
    quot_d.darkest  = data_i.darkest;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_valid_q <= 1'b0;
    end else if (en_i) begin
      quot_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
    end
  end

  // Remainder check bumps the estimate when it fell one short.
  always_comb begin
    back = BACK_W'(quot_q.quot_est) * BACK_W'(quot_q.count);
    rem  = quot_q.scaled - back[Q_W-1:0];
    quot = (rem >= Q_W'(quot_q.count)) ? quot_q.quot_est + Q_W'(1) : quot_q.quot_est;
    if (quot_q.count == '0) begin
      radiance_d = RAD_W'(quot_q.darkest);
      fallback_d = 1'b1;
    end else begin
      radiance_d = (quot > Q_W'(RAD_MAX)) ? RAD_MAX : quot[RAD_W-1:0];
      fallback_d = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= quot_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      radiance_q <= radiance_d;
      fallback_q <= fallback_d;
    end
  end

  assign valid_o    = out_valid_q;
  assign radiance_o = radiance_q;
  assign fallback_o = fallback_q;
  assign quot_o     = quot_q;

endmodule

// File: sv/hdr_exposure_merge.sv
// HDR exposure merge: fuses one pixel from each exposure into a Q4.16 radiance.
//
// Input stream: one word per pixel carries one Q0.16 sample per exposure,
// darkest exposure in the lowest 16 bits. Output stream: one word per pixel
// with the saturated Q4.16 radiance in tdata and the fallback flag in tuser,
// set when no sample was usable and the darkest sample was passed through.
// Thresholds and inverse gains are to be written through the cfg port only
// while the stream is idle, which the block itself does not enforce; they take effect on the next word.
//
// The datapath is four register stages: weight and gain multiply, rounded
// sum, reciprocal multiply, and remainder correction into the output
// register. One word is taken every cycle while the receiver keeps up.
// When the receiver stalls the whole pipeline holds in place; s_axis_tready
// drops only while the output register holds a word that is not taken, and
// no word is dropped or repeated. Reset empties the pipeline and restores
// the register defaults (thresholds 655 and 64880, all gains 1.0).
module hdr_exposure_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: sample_darkest, sample_second, sample_third, sample_brightest.
  input  logic [hem_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: radiance, then zero padding.
  output logic [hem_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Fields from bit 0: fallback_used.
  output logic                              m_axis_tuser,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [hem_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [hem_pkg::CFG_W-1:0]         cfg_data_i
);
  import hem_pkg::*;

  cfg_t             cfg;
  logic             pipe_en;
  logic             prod_valid;
  prod_t            prod_data;
  logic             sum_valid;
  sum_t             sum_data;
  quot_t            quot_data;
  logic [RAD_W-1:0] radiance;
  logic             fallback;

  // The pipeline moves whenever the output register is empty or being taken.
  assign pipe_en       = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = pipe_en;

  hem_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hem_weight_mul u_weight (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .valid_i   (s_axis_tvalid),
    .samples_i (s_axis_tdata[NUM_EXPOSURES*SAMPLE_W-1:0]),
    .cfg_i     (cfg),
    .valid_o   (prod_valid),
    .data_o    (prod_data)
  );

  hem_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (prod_valid),
    .data_i  (prod_data),
    .valid_o (sum_valid),
    .data_o  (sum_data)
  );

  hem_divide u_divide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (sum_valid),
    .data_i     (sum_data),
    .valid_o    (m_axis_tvalid),
    .radiance_o (radiance),
    .fallback_o (fallback),
    .quot_o     (quot_data)
  );

  assign m_axis_tdata = OUT_TDATA_W'(radiance);
  assign m_axis_tuser = fallback;

  // The weight count never exceeds the number of exposures.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_valid |-> (prod_data.count <= CNT_W'(NUM_EXPOSURES)))
    else $error("weight count exceeds exposure count");

  // The reciprocal estimate never overshoots the dividend.
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (quot_data.count != '0) |-> (quot_data.quot_est <= quot_data.scaled))
    else $error("quotient estimate above dividend");

  // A fallback result is the darkest sample, so its integer bits are clear.
  a_fallback_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (radiance[RAD_W-1:SAMPLE_W] == '0))
    else $error("fallback radiance out of sample range");

  // A stall freezes the inner stages.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> ($stable(sum_data) && $stable(sum_valid)))
    else $error("pipeline moved during a stall");

endmodule
